[hdl/assert_macros.svh]
// Assertion macros for the circle center RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define C3P_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define C3P_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/c3p_pkg.sv]
// Widths, codes and pipeline bundle types for the circle center block
`default_nettype none
package c3p_pkg;
    localparam int CW  = 32;          // coordinate
    localparam int DW  = CW + 1;      // coordinate difference
    localparam int PW  = 2 * DW;      // product of two differences
    localparam int CRW = PW + 1;      // cross product
    localparam int PPW = 2 * DW + 1;  // difference times half of a sum of squares
    localparam int NW  = DW + PW + 1; // difference times sum of squares
    localparam int NDW = NW + 1;      // quotient numerator
    localparam int BW  = CRW + 1;     // divisor, 2*|cross|
    localparam int RW  = NDW + 1;     // divider remainder
    localparam int QB  = CW + 2;      // quotient bits kept before saturation
    localparam int RB  = PW / 2;      // root bits
    localparam int SQW = PW + 1;      // root work width
    localparam int PTW = 16;          // point tolerance
    localparam int CTW = 32;          // colinear tolerance
    localparam int CFG_DW = 32;
    localparam int CFG_IW = 2;
    localparam int DIV_LAT = QB + 1;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_GENERAL  = 2'd0,
        ST_CLOSED   = 2'd1,
        ST_COLINEAR = 2'd2,
        ST_OVERFLOW = 2'd3
    } c3p_status_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_POINT_TOL = 2'd0,
        REG_COLIN_TOL = 2'd1
    } c3p_reg_t;

    typedef struct packed {
        logic                 closed;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] mx;
        logic signed [CW-1:0] my;
    } c3p_pts_t;

    typedef struct packed {
        c3p_pts_t pts;
        logic     colin;
        logic     neg_x;
        logic     neg_y;
    } c3p_div_side_t;

    typedef struct packed {
        logic                 closed;
        logic                 colin;
        logic                 sat;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } c3p_sq_side_t;
endpackage
`default_nettype wire

[hdl/circle_center_from_three_points.sv]
// Circle center and radius through three points, deep pipeline
//
//  channel  | handshake          | payload
//  s_       | s_valid / s_ready  | first, mid, last point (x, y), signed Q16.16
//  m_       | m_valid / m_ready  | center_x, center_y, radius, status
//  cfg_     | cfg_wr_en          | cfg_index, cfg_wr_data (write only)
//
// One transaction per cycle unless m_ready stalls. Stages: 8 arithmetic, a
// 35 stage divider (range check, then one quotient bit per stage), 5 of center and
// squared distance, a 33 stage square root (one root bit per stage), output.
// Synchronous active-low reset clears the valid bits and the tolerances to 1.
// A stall on m_ready freezes every stage together; nothing is dropped.
`default_nettype none
`include "assert_macros.svh"
module circle_center_from_three_points (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [c3p_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [c3p_pkg::CFG_DW-1:0]    cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [c3p_pkg::CW-1:0] s_first_x,
    input  wire logic signed [c3p_pkg::CW-1:0] s_first_y,
    input  wire logic signed [c3p_pkg::CW-1:0] s_mid_x,
    input  wire logic signed [c3p_pkg::CW-1:0] s_mid_y,
    input  wire logic signed [c3p_pkg::CW-1:0] s_last_x,
    input  wire logic signed [c3p_pkg::CW-1:0] s_last_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [c3p_pkg::CW-1:0]      m_center_x,
    output logic signed [c3p_pkg::CW-1:0]      m_center_y,
    output logic        [c3p_pkg::CW-1:0]      m_radius,
    output logic        [1:0]                  m_status
);
    import c3p_pkg::*;

    typedef struct packed {
        logic                 sat;
        logic signed [CW-1:0] val;
    } clamp_t;

    function automatic clamp_t clamp_center(input logic closed, input logic ovf,
                                            input logic neg,
                                            input logic signed [QB+1:0] sum,
                                            input logic signed [CW-1:0] mid);
        clamp_t r;
        r.sat = 1'b0;
        r.val = sum[CW-1:0];
        if (closed) begin
            r.val = mid;
        end else if (ovf) begin
            r.sat = 1'b1;
            r.val = neg ? C_MIN : C_MAX;
        end else if (sum > (QB+2)'(C_MAX)) begin
            r.sat = 1'b1;
            r.val = C_MAX;
        end else if (sum < (QB+2)'(C_MIN)) begin
            r.sat = 1'b1;
            r.val = C_MIN;
        end
        return r;
    endfunction

    logic [PTW-1:0] point_tol_reg;
    logic [CTW-1:0] colin_tol_reg;
    logic           m_valid_reg;
    logic           adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_tol_reg <= PTW'(1);
            colin_tol_reg <= CTW'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POINT_TOL: point_tol_reg <= cfg_wr_data[PTW-1:0];
                REG_COLIN_TOL: colin_tol_reg <= cfg_wr_data[CTW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: differences, closed-circle test, midpoint
    logic signed [DW-1:0] ax_next, ay_next, bx_next, by_next, dx13, dy13, sxm, sym;
    logic        [DW-1:0] adx13, ady13;
    c3p_pts_t             pts1_next;

    always_comb begin
        ax_next = DW'(s_first_x) - DW'(s_mid_x);
        ay_next = DW'(s_first_y) - DW'(s_mid_y);
        bx_next = DW'(s_last_x) - DW'(s_mid_x);
        by_next = DW'(s_last_y) - DW'(s_mid_y);
        dx13    = DW'(s_first_x) - DW'(s_last_x);
        dy13    = DW'(s_first_y) - DW'(s_last_y);
        adx13   = dx13[DW-1] ? DW'(-dx13) : DW'(dx13);
        ady13   = dy13[DW-1] ? DW'(-dy13) : DW'(dy13);
        sxm     = DW'(s_first_x) + DW'(s_mid_x);
        sym     = DW'(s_first_y) + DW'(s_mid_y);
        pts1_next.closed = (adx13 <= DW'(point_tol_reg)) && (ady13 <= DW'(point_tol_reg));
        pts1_next.x1 = s_first_x;
        pts1_next.y1 = s_first_y;
        pts1_next.x2 = s_mid_x;
        pts1_next.y2 = s_mid_y;
        pts1_next.mx = sxm[DW-1:1];   // floor of half
        pts1_next.my = sym[DW-1:1];
    end

    logic                 s1_valid_reg;
    logic signed [DW-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    c3p_pts_t             s1_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ax_reg  <= ax_next;
            s1_ay_reg  <= ay_next;
            s1_bx_reg  <= bx_next;
            s1_by_reg  <= by_next;
            s1_pts_reg <= pts1_next;
        end
    end

    // ---------------- stage 2: six products
    logic                 s2_valid_reg;
    logic signed [PW-1:0] s2_axby_reg, s2_aybx_reg, s2_axax_reg, s2_ayay_reg;
    logic signed [PW-1:0] s2_bxbx_reg, s2_byby_reg;
    logic signed [DW-1:0] s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    c3p_pts_t             s2_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_axby_reg <= s1_ax_reg * s1_by_reg;
            s2_aybx_reg <= s1_ay_reg * s1_bx_reg;
            s2_axax_reg <= s1_ax_reg * s1_ax_reg;
            s2_ayay_reg <= s1_ay_reg * s1_ay_reg;
            s2_bxbx_reg <= s1_bx_reg * s1_bx_reg;
            s2_byby_reg <= s1_by_reg * s1_by_reg;
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_bx_reg   <= s1_bx_reg;
            s2_by_reg   <= s1_by_reg;
            s2_pts_reg  <= s1_pts_reg;
        end
    end

    // ---------------- stage 3: cross product, sums of squares
    logic                  s3_valid_reg;
    logic signed [CRW-1:0] s3_cr_reg;
    logic        [PW-1:0]  s3_sa_reg, s3_sb_reg;
    logic signed [DW-1:0]  s3_ax_reg, s3_ay_reg, s3_bx_reg, s3_by_reg;
    c3p_pts_t              s3_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_cr_reg  <= CRW'(s2_axby_reg) - CRW'(s2_aybx_reg);
            s3_sa_reg  <= $unsigned(s2_axax_reg) + $unsigned(s2_ayay_reg);
            s3_sb_reg  <= $unsigned(s2_bxbx_reg) + $unsigned(s2_byby_reg);
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_bx_reg  <= s2_bx_reg;
            s3_by_reg  <= s2_by_reg;
            s3_pts_reg <= s2_pts_reg;
        end
    end

    // ---------------- stage 4: |cross|, colinear test, split partial products
    logic [CRW-1:0] acr_next;
    logic           colin_next;

    always_comb begin
        acr_next   = s3_cr_reg[CRW-1] ? CRW'(-s3_cr_reg) : CRW'(s3_cr_reg);
        colin_next = !s3_pts_reg.closed && (acr_next <= CRW'(colin_tol_reg));
    end

    logic                  s4_valid_reg;
    logic        [CRW-1:0] s4_acr_reg;
    logic                  s4_crneg_reg, s4_colin_reg;
    logic signed [PPW-1:0] s4_bysa_l_reg, s4_bysa_h_reg, s4_aysb_l_reg, s4_aysb_h_reg;
    logic signed [PPW-1:0] s4_axsb_l_reg, s4_axsb_h_reg, s4_bxsa_l_reg, s4_bxsa_h_reg;
    c3p_pts_t              s4_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_acr_reg    <= acr_next;
            s4_crneg_reg  <= s3_cr_reg[CRW-1];
            s4_colin_reg  <= colin_next;
            s4_bysa_l_reg <= s3_by_reg * $signed({1'b0, s3_sa_reg[DW-1:0]});
            s4_bysa_h_reg <= s3_by_reg * $signed({1'b0, s3_sa_reg[PW-1:DW]});
            s4_aysb_l_reg <= s3_ay_reg * $signed({1'b0, s3_sb_reg[DW-1:0]});
            s4_aysb_h_reg <= s3_ay_reg * $signed({1'b0, s3_sb_reg[PW-1:DW]});
            s4_axsb_l_reg <= s3_ax_reg * $signed({1'b0, s3_sb_reg[DW-1:0]});
            s4_axsb_h_reg <= s3_ax_reg * $signed({1'b0, s3_sb_reg[PW-1:DW]});
            s4_bxsa_l_reg <= s3_bx_reg * $signed({1'b0, s3_sa_reg[DW-1:0]});
            s4_bxsa_h_reg <= s3_bx_reg * $signed({1'b0, s3_sa_reg[PW-1:DW]});
            s4_pts_reg    <= s3_pts_reg;
        end
    end

    // ---------------- stage 5: recombine partial products
    logic                 s5_valid_reg;
    logic signed [NW-1:0] s5_bysa_reg, s5_aysb_reg, s5_axsb_reg, s5_bxsa_reg;
    logic        [CRW-1:0] s5_acr_reg;
    logic                 s5_crneg_reg, s5_colin_reg;
    c3p_pts_t             s5_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_bysa_reg  <= (NW'(s4_bysa_h_reg) <<< DW) + NW'(s4_bysa_l_reg);
            s5_aysb_reg  <= (NW'(s4_aysb_h_reg) <<< DW) + NW'(s4_aysb_l_reg);
            s5_axsb_reg  <= (NW'(s4_axsb_h_reg) <<< DW) + NW'(s4_axsb_l_reg);
            s5_bxsa_reg  <= (NW'(s4_bxsa_h_reg) <<< DW) + NW'(s4_bxsa_l_reg);
            s5_acr_reg   <= s4_acr_reg;
            s5_crneg_reg <= s4_crneg_reg;
            s5_colin_reg <= s4_colin_reg;
            s5_pts_reg   <= s4_pts_reg;
        end
    end

    // ---------------- stage 6: numerators
    logic                  s6_valid_reg;
    logic signed [NDW-1:0] s6_nx_reg, s6_ny_reg;
    logic        [CRW-1:0] s6_acr_reg;
    logic                  s6_crneg_reg, s6_colin_reg;
    c3p_pts_t              s6_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_nx_reg    <= NDW'(s5_bysa_reg) - NDW'(s5_aysb_reg);
            s6_ny_reg    <= NDW'(s5_axsb_reg) - NDW'(s5_bxsa_reg);
            s6_acr_reg   <= s5_acr_reg;
            s6_crneg_reg <= s5_crneg_reg;
            s6_colin_reg <= s5_colin_reg;
            s6_pts_reg   <= s5_pts_reg;
        end
    end

    // ---------------- stage 7: magnitudes and quotient signs
    logic                 s7_valid_reg;
    logic [NDW-1:0]       s7_anx_reg, s7_any_reg;
    logic [CRW-1:0]       s7_acr_reg;
    logic                 s7_negx_reg, s7_negy_reg, s7_colin_reg;
    c3p_pts_t             s7_pts_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_anx_reg   <= s6_nx_reg[NDW-1] ? NDW'(-s6_nx_reg) : NDW'(s6_nx_reg);
            s7_any_reg   <= s6_ny_reg[NDW-1] ? NDW'(-s6_ny_reg) : NDW'(s6_ny_reg);
            s7_negx_reg  <= s6_nx_reg[NDW-1] ^ s6_crneg_reg;
            s7_negy_reg  <= s6_ny_reg[NDW-1] ^ s6_crneg_reg;
            s7_acr_reg   <= s6_acr_reg;
            s7_colin_reg <= s6_colin_reg;
            s7_pts_reg   <= s6_pts_reg;
        end
    end

    // ---------------- stage 8: rounded quotient = (|n| + |cr|) / (2|cr|)
    logic          s8_valid_reg;
    logic [RW-1:0] s8_ax_reg, s8_ay_reg;
    logic [BW-1:0] s8_b_reg;
    c3p_div_side_t s8_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_ax_reg         <= RW'(s7_anx_reg) + RW'(s7_acr_reg);
            s8_ay_reg         <= RW'(s7_any_reg) + RW'(s7_acr_reg);
            s8_b_reg          <= {s7_acr_reg, 1'b0};
            s8_side_reg.pts   <= s7_pts_reg;
            s8_side_reg.colin <= s7_colin_reg;
            s8_side_reg.neg_x <= s7_negx_reg;
            s8_side_reg.neg_y <= s7_negy_reg;
        end
    end

    // ---------------- dividers, side data delayed alongside
    logic [QB-1:0] qx, qy;
    logic          ovfx, ovfy;

    c3p_div u_div_x (
        .aclk     (aclk),
        .adv      (adv),
        .dividend (s8_ax_reg),
        .divisor  (s8_b_reg),
        .quotient (qx),
        .ovf      (ovfx)
    );

    c3p_div u_div_y (
        .aclk     (aclk),
        .adv      (adv),
        .dividend (s8_ay_reg),
        .divisor  (s8_b_reg),
        .quotient (qy),
        .ovf      (ovfy)
    );

    logic          dv_valid_reg [DIV_LAT];
    c3p_div_side_t dv_side_reg  [DIV_LAT];

    for (genvar i = 0; i < DIV_LAT; i++) begin : g_dv
        logic          vin;
        c3p_div_side_t sin;
        if (i == 0) begin : g_first
            assign vin = s8_valid_reg;
            assign sin = s8_side_reg;
        end else begin : g_rest
            assign vin = dv_valid_reg[i-1];
            assign sin = dv_side_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[i] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[i] <= vin;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_side_reg[i] <= sin;
            end
        end
    end

    // ---------------- P1: signed offsets
    logic                 p1_valid_reg;
    logic signed [QB:0]   p1_offx_reg, p1_offy_reg;
    logic                 p1_ovfx_reg, p1_ovfy_reg;
    c3p_div_side_t        p1_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_offx_reg <= dv_side_reg[DIV_LAT-1].neg_x ? -$signed({1'b0, qx})
                                                        : $signed({1'b0, qx});
            p1_offy_reg <= dv_side_reg[DIV_LAT-1].neg_y ? -$signed({1'b0, qy})
                                                        : $signed({1'b0, qy});
            p1_ovfx_reg <= ovfx;
            p1_ovfy_reg <= ovfy;
            p1_side_reg <= dv_side_reg[DIV_LAT-1];
        end
    end

    // ---------------- P2: center and saturation
    clamp_t cx_c, cy_c;

    always_comb begin
        cx_c = clamp_center(p1_side_reg.pts.closed, p1_ovfx_reg, p1_side_reg.neg_x,
                            (QB+2)'(p1_side_reg.pts.x2) + (QB+2)'(p1_offx_reg),
                            p1_side_reg.pts.mx);
        cy_c = clamp_center(p1_side_reg.pts.closed, p1_ovfy_reg, p1_side_reg.neg_y,
                            (QB+2)'(p1_side_reg.pts.y2) + (QB+2)'(p1_offy_reg),
                            p1_side_reg.pts.my);
    end

    logic                 p2_valid_reg;
    logic signed [CW-1:0] p2_x1_reg, p2_y1_reg;
    c3p_sq_side_t         p2_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_side_reg.closed <= p1_side_reg.pts.closed;
            p2_side_reg.colin  <= p1_side_reg.colin;
            p2_side_reg.sat    <= cx_c.sat || cy_c.sat;
            p2_side_reg.cx     <= cx_c.val;
            p2_side_reg.cy     <= cy_c.val;
            p2_x1_reg          <= p1_side_reg.pts.x1;
            p2_y1_reg          <= p1_side_reg.pts.y1;
        end
    end

    // ---------------- P3..P5: squared distance to the first point
    logic                 p3_valid_reg, p4_valid_reg, p5_valid_reg;
    logic signed [DW-1:0] p3_ex_reg, p3_ey_reg;
    logic signed [PW-1:0] p4_ex2_reg, p4_ey2_reg;
    logic        [PW-1:0] p5_s_reg;
    c3p_sq_side_t         p3_side_reg, p4_side_reg, p5_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_ex_reg   <= DW'(p2_side_reg.cx) - DW'(p2_x1_reg);
            p3_ey_reg   <= DW'(p2_side_reg.cy) - DW'(p2_y1_reg);
            p3_side_reg <= p2_side_reg;
            p4_ex2_reg  <= p3_ex_reg * p3_ex_reg;
            p4_ey2_reg  <= p3_ey_reg * p3_ey_reg;
            p4_side_reg <= p3_side_reg;
            p5_s_reg    <= $unsigned(p4_ex2_reg) + $unsigned(p4_ey2_reg);
            p5_side_reg <= p4_side_reg;
        end
    end

    // ---------------- square root, one root bit per stage
    logic [SQW-1:0] sq_rem_reg   [RB];
    logic [SQW-1:0] sq_root_reg  [RB];
    logic           sq_valid_reg [RB];
    c3p_sq_side_t   sq_side_reg  [RB];

    for (genvar i = 0; i < RB; i++) begin : g_sq
        localparam logic [SQW-1:0] ONE = SQW'(1) << (2 * (RB - 1 - i));
        logic [SQW-1:0] rem_in, root_in, trial;
        logic           vin;
        c3p_sq_side_t   sin;
        if (i == 0) begin : g_first
            assign rem_in  = SQW'(p5_s_reg);
            assign root_in = '0;
            assign vin     = p5_valid_reg;
            assign sin     = p5_side_reg;
        end else begin : g_rest
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
            assign vin     = sq_valid_reg[i-1];
            assign sin     = sq_side_reg[i-1];
        end
        assign trial = root_in + ONE;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[i] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[i] <= vin;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_in >= trial) begin
                    sq_rem_reg[i]  <= rem_in - trial;
                    sq_root_reg[i] <= (root_in >> 1) + ONE;
                end else begin
                    sq_rem_reg[i]  <= rem_in;
                    sq_root_reg[i] <= root_in >> 1;
                end
                sq_side_reg[i] <= sin;
            end
        end
    end

    // ---------------- output register: round root, pick status
    logic [RB:0]          r_round;
    c3p_sq_side_t         sq_last;
    logic signed [CW-1:0] cx_next, cy_next;
    logic [CW-1:0]        radius_next;
    c3p_status_t          status_next;

    always_comb begin
        sq_last = sq_side_reg[RB-1];
        r_round = (RB+1)'(sq_root_reg[RB-1][RB-1:0])
                  + (RB+1)'(sq_rem_reg[RB-1] > sq_root_reg[RB-1]);
        cx_next     = sq_last.cx;
        cy_next     = sq_last.cy;
        radius_next = r_round[CW-1:0];
        status_next = sq_last.closed ? ST_CLOSED : ST_GENERAL;
        if (sq_last.colin) begin
            cx_next     = '0;
            cy_next     = '0;
            radius_next = '0;
            status_next = ST_COLINEAR;
        end else if (sq_last.sat || (r_round[RB:CW] != '0)) begin
            radius_next = '1;
            status_next = ST_OVERFLOW;
        end
    end

    logic signed [CW-1:0] m_cx_reg, m_cy_reg;
    logic [CW-1:0]        m_radius_reg;
    c3p_status_t          m_status_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_cx_reg     <= cx_next;
            m_cy_reg     <= cy_next;
            m_radius_reg <= radius_next;
            m_status_reg <= status_next;
        end
    end

    // valid bits of the named stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            p1_valid_reg <= dv_valid_reg[DIV_LAT-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            m_valid_reg  <= sq_valid_reg[RB-1];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_center_x = m_cx_reg;
    assign m_center_y = m_cy_reg;
    assign m_radius   = m_radius_reg;
    assign m_status   = m_status_reg;

    `C3P_ASSERT(a_colin_zero, aclk, aresetn, m_valid && m_status == ST_COLINEAR, m_center_x == '0 && m_center_y == '0 && m_radius == '0, "colinear transaction with nonzero result")
    `C3P_ASSERT(a_ovf_radius, aclk, aresetn, m_valid && m_status == ST_OVERFLOW, m_radius == '1, "overflow transaction without saturated radius")
    `C3P_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, s1_valid_reg, "accepted transaction missing from first stage")
endmodule
`default_nettype wire

[hdl/c3p_div.sv]
// Pipelined restoring divider: a range-check stage, then one quotient bit per stage
`default_nettype none
module c3p_div (
    input  wire logic                   aclk,
    input  wire logic                   adv,
    input  wire logic [c3p_pkg::RW-1:0] dividend,
    input  wire logic [c3p_pkg::BW-1:0] divisor,
    output logic      [c3p_pkg::QB-1:0] quotient,
    output logic                        ovf
);
    import c3p_pkg::*;

    logic [RW-1:0] rem_reg [DIV_LAT];
    logic [BW-1:0] b_reg   [DIV_LAT];
    logic [QB-1:0] q_reg   [DIV_LAT];
    logic          ovf_reg [DIV_LAT];

    // stage 0: quotient would not fit in QB bits
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= dividend;
            b_reg[0]   <= divisor;
            q_reg[0]   <= '0;
            ovf_reg[0] <= dividend >= (RW'(divisor) << QB);
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
        logic [RW-1:0] trial;
        logic          take;
        assign trial = RW'(b_reg[k-1]) << (QB - k);
        assign take  = rem_reg[k-1] >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k] <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                b_reg[k]   <= b_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quotient = q_reg[DIV_LAT-1];
    assign ovf      = ovf_reg[DIV_LAT-1];
endmodule
`default_nettype wire
